/* hdl/dra_pkg.sv */
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types, codes and helper functions for the debug register allocator.
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int UNIT_COUNT = 4;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

  localparam int TYPE_SHIFT = 16;
  localparam int LEN_SHIFT  = 18;

  // map entries hold a unit number, or this code for no unit
  localparam logic [2:0] UNMAPPED = 3'd4;

  localparam logic [2:0] CMD_WATCH_SET   = 3'd0;
  localparam logic [2:0] CMD_WATCH_CLEAR = 3'd1;
  localparam logic [2:0] CMD_BREAK_SET   = 3'd2;
  localparam logic [2:0] CMD_BREAK_CLEAR = 3'd3;
  localparam logic [2:0] CMD_HIT         = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_UNIT  = 2'd2;
  localparam logic [1:0] ST_NOT_OURS = 2'd3;

  localparam logic [1:0] ACT_DISABLE  = 2'd0;
  localparam logic [1:0] ACT_CONTINUE = 2'd1;

  localparam logic [1:0] RW_EXECUTE   = 2'd0;
  localparam logic [1:0] RW_WRITE     = 2'd1;
  localparam logic [1:0] RW_READWRITE = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  slot;
    logic [63:0] address;
    logic [3:0]  access_size;
    logic        write_only;
    logic [3:0]  hit_status;
    logic [1:0]  action;
    logic [63:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  unit;
    logic [31:0] control_word;
    logic [7:0]  hit_slot;
    logic        hit_is_break;
    logic [63:0] hit_address;
    logic [63:0] prior_value;
    logic        resume_once;
    logic        pass_on;
  } out_item_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic [63:0] mask_by_len(input logic [63:0] v, input logic [1:0] len);
    logic [63:0] r;
    case (len)
      2'd0:    r = {56'd0, v[7:0]};
      2'd1:    r = {48'd0, v[15:0]};
      2'd3:    r = {32'd0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic size_ok(input logic [3:0] size);
    return (size == 4'd1) || (size == 4'd2) || (size == 4'd4) || (size == 4'd8);
  endfunction

  // length code: 1 byte 0, 2 bytes 1, 8 bytes 2, 4 bytes 3
  function automatic logic [1:0] len_code(input logic [3:0] size);
    logic [1:0] r;
    case (size)
      4'd1:    r = 2'd0;
      4'd2:    r = 2'd1;
      4'd8:    r = 2'd2;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

/* hdl/debug_register_allocator_top.sv */
// ----------------------------------------------------------------------------
// debug_register_allocator_top
// Shares four hardware debug units between logical watch and break slots.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o / in_item_i carry one command item
// (watch set/clear, break set/clear, hit). Output channel: out_valid_o /
// out_stall_i / out_item_o carry exactly one result item per command.
// An item is taken at an edge with valid high and stall low.
// A taken command waits in the input register until the result register is
// free, is then evaluated against the unit table, and its result is shown
// from the result register. The input channel stalls while the command is
// held, so a new item is taken only once the last one has been evaluated.
// The result register lets the next item be taken while a result waits;
// if the receiver keeps stalling, the held command waits for the result
// register and the input channel stalls until it drains.
// Reset empties the unit table and unmaps every slot at once; no item is
// lost or duplicated across stalls on either side.
// ----------------------------------------------------------------------------
module debug_register_allocator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dra_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dra_pkg::out_item_t out_item_o
);

  dra_pkg::ctrl_cmd_t  cmd;
  dra_pkg::dp_status_t dp_status;

  dra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  dra_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hdl/dra_ctrl.sv */
// ----------------------------------------------------------------------------
// dra_ctrl
// Command sequencer: takes an item, then runs it once the result slot frees.
// ----------------------------------------------------------------------------
module dra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dra_pkg::dp_status_t status_i,
  output dra_pkg::ctrl_cmd_t  cmd_o
);

  dra_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dra_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dra_pkg::S_IDLE: begin
        if (in_valid_i) state_d = dra_pkg::S_EXEC;
      end
      dra_pkg::S_EXEC: begin
        if (status_i.out_free) state_d = dra_pkg::S_IDLE;
      end
      default: state_d = dra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      dra_pkg::S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      dra_pkg::S_EXEC: begin
        cmd_o.execute = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/dra_datapath.sv */
// ----------------------------------------------------------------------------
// dra_datapath
// Unit table, slot maps, command evaluation and the result register.
// ----------------------------------------------------------------------------
module dra_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dra_pkg::ctrl_cmd_t  cmd_i,
  output dra_pkg::dp_status_t status_o,
  input  dra_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dra_pkg::out_item_t  out_item_o
);

  localparam int UC = dra_pkg::UNIT_COUNT;
  localparam int IW = dra_pkg::SLOT_IDX_W;

  dra_pkg::in_item_t  item_q;
  dra_pkg::out_item_t out_q, res;
  logic               out_valid_q, out_valid_d;

  logic [UC-1:0] used_q, used_d;
  logic [63:0]   addr_q [UC];
  logic [63:0]   addr_d [UC];
  logic [1:0]    len_q  [UC];
  logic [1:0]    len_d  [UC];
  logic [UC-1:0] wonly_q, wonly_d;
  logic [UC-1:0] brk_q, brk_d;
  logic [7:0]    owner_q [UC];
  logic [7:0]    owner_d [UC];
  logic [63:0]   last_q [UC];
  logic [63:0]   last_d [UC];

  logic [2:0] wmap_q [dra_pkg::SLOT_COUNT];
  logic [2:0] bmap_q [dra_pkg::SLOT_COUNT];

  // one write port per map
  logic          wmap_we, bmap_we;
  logic [IW-1:0] map_idx;
  logic [2:0]    map_val;

  logic          slot_ok, is_watch, free_found, hit_found;
  logic [1:0]    free_u, hit_u, mu;
  logic [IW-1:0] slot_idx;
  logic [2:0]    map_rd;
  logic [31:0]   cw;

  assign slot_idx = item_q.slot[IW-1:0];
  assign slot_ok  = {1'b0, item_q.slot} < dra_pkg::SLOT_LIMIT;
  assign is_watch = (item_q.command == dra_pkg::CMD_WATCH_SET) ||
                    (item_q.command == dra_pkg::CMD_WATCH_CLEAR);
  assign map_rd   = is_watch ? wmap_q[slot_idx] : bmap_q[slot_idx];
  assign mu       = map_rd[1:0];

  // lowest free unit and lowest flagged unit in use
  always_comb begin
    free_found = 1'b0;
    free_u     = '0;
    hit_found  = 1'b0;
    hit_u      = '0;
    for (int i = UC - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_u     = 2'(i);
      end
      if (used_q[i] && item_q.hit_status[i]) begin
        hit_found = 1'b1;
        hit_u     = 2'(i);
      end
    end
  end

  always_comb begin
    used_d  = used_q;
    addr_d  = addr_q;
    len_d   = len_q;
    wonly_d = wonly_q;
    brk_d   = brk_q;
    owner_d = owner_q;
    last_d  = last_q;
    wmap_we = 1'b0;
    bmap_we = 1'b0;
    map_idx = slot_idx;
    map_val = dra_pkg::UNMAPPED;
    res     = '0;
    res.status = dra_pkg::ST_OK;

    case (item_q.command)
      dra_pkg::CMD_WATCH_SET, dra_pkg::CMD_BREAK_SET: begin
        if (!slot_ok) begin
          res.status = dra_pkg::ST_INVALID;
        end else if (is_watch && !dra_pkg::size_ok(item_q.access_size)) begin
          res.status = dra_pkg::ST_INVALID;
        end else if (!free_found) begin
          res.status = dra_pkg::ST_NO_UNIT;
        end else begin
          used_d[free_u]  = 1'b1;
          addr_d[free_u]  = item_q.address;
          owner_d[free_u] = item_q.slot;
          map_val         = {1'b0, free_u};
          res.unit        = free_u;
          if (is_watch) begin
            len_d[free_u]   = dra_pkg::len_code(item_q.access_size);
            wonly_d[free_u] = item_q.write_only;
            brk_d[free_u]   = 1'b0;
            last_d[free_u]  = dra_pkg::mask_by_len(item_q.data_value,
                                                   dra_pkg::len_code(item_q.access_size));
            wmap_we         = 1'b1;
          end else begin
            len_d[free_u]   = 2'd0;
            wonly_d[free_u] = 1'b0;
            brk_d[free_u]   = 1'b1;
            bmap_we         = 1'b1;
          end
        end
      end
      dra_pkg::CMD_WATCH_CLEAR, dra_pkg::CMD_BREAK_CLEAR: begin
        if (!slot_ok) begin
          res.status = dra_pkg::ST_INVALID;
        end else if (!map_rd[2]) begin
          used_d[mu] = 1'b0;
          wmap_we    = is_watch;
          bmap_we    = !is_watch;
          res.unit   = mu;
        end
      end
      dra_pkg::CMD_HIT: begin
        if (!hit_found) begin
          res.status = dra_pkg::ST_NOT_OURS;
        end else begin
          res.unit         = hit_u;
          res.hit_slot     = owner_q[hit_u];
          res.hit_is_break = brk_q[hit_u];
          res.hit_address  = addr_q[hit_u];
          if (!brk_q[hit_u] && (addr_q[hit_u] != 64'd0)) begin
            res.prior_value = last_q[hit_u];
            last_d[hit_u]   = dra_pkg::mask_by_len(item_q.data_value, len_q[hit_u]);
          end
          if (item_q.action == dra_pkg::ACT_DISABLE) begin
            used_d[hit_u] = 1'b0;
            map_idx       = owner_q[hit_u][IW-1:0];
            // unmap the owner even if its entry now names another unit
            if ({1'b0, owner_q[hit_u]} < dra_pkg::SLOT_LIMIT) begin
              wmap_we = !brk_q[hit_u];
              bmap_we = brk_q[hit_u];
            end
          end else if (item_q.action == dra_pkg::ACT_CONTINUE) begin
            res.resume_once = brk_q[hit_u];
          end else begin
            res.pass_on = 1'b1;
          end
        end
      end
      default: res.status = dra_pkg::ST_INVALID;
    endcase

    // control word from the table after the command
    cw = '0;
    for (int i = 0; i < UC; i++) begin
      if (used_d[i]) begin
        cw[2*i] = 1'b1;
        if (!brk_d[i]) begin
          cw[dra_pkg::TYPE_SHIFT+4*i +: 2] = wonly_d[i] ? dra_pkg::RW_WRITE
                                                        : dra_pkg::RW_READWRITE;
          cw[dra_pkg::LEN_SHIFT+4*i +: 2]  = len_d[i];
        end else begin
          cw[dra_pkg::TYPE_SHIFT+4*i +: 2] = dra_pkg::RW_EXECUTE;
        end
      end
    end
    res.control_word = cw;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.execute) out_valid_d = 1'b1;
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < dra_pkg::SLOT_COUNT; s++) begin
        wmap_q[s] <= dra_pkg::UNMAPPED;
        bmap_q[s] <= dra_pkg::UNMAPPED;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.execute) begin
        used_q <= used_d;
        if (wmap_we) wmap_q[map_idx] <= map_val;
        if (bmap_we) bmap_q[map_idx] <= map_val;
      end
    end
  end

  // payload: unit fields are only read once their unit has been set
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (cmd_i.execute) begin
      out_q   <= res;
      addr_q  <= addr_d;
      len_q   <= len_d;
      wonly_q <= wonly_d;
      brk_q   <= brk_d;
      owner_q <= owner_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/dra_checker.sv */
// ----------------------------------------------------------------------------
// dra_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dra_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input dra_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dra_pkg::out_item_t out_item_o
);

  // a stalled input item stays up and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input item dropped or changed");

  // a stalled result stays up and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

  // no free unit means every enable bit is set
  a_no_unit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == dra_pkg::ST_NO_UNIT) |->
      (out_item_o.control_word[0] && out_item_o.control_word[2] &&
       out_item_o.control_word[4] && out_item_o.control_word[6]))
    else $error("no-unit status with a unit still free");

  a_cw_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.control_word[15:8] == 8'd0) &&
      !out_item_o.control_word[1] && !out_item_o.control_word[3] &&
      !out_item_o.control_word[5] && !out_item_o.control_word[7])
    else $error("reserved control word bits set");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.resume_once && out_item_o.pass_on))
    else $error("resume and pass-on both set");

endmodule

bind debug_register_allocator_top dra_checker u_dra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
